// ===== design/rv32_pkg.sv =====
package rv32_pkg;

   localparam int XLEN_BITS = 32;

   typedef struct packed {
      logic        mode;
      logic [31:0] instr;
      logic [31:0] pc;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  mem_op;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] mem_wdata;
      logic        wb_enable;
      logic [4:0]  wb_reg;
      logic [31:0] wb_value;
      logic [2:0]  status;
      logic [31:0] halt_code;
   } rsp_type;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_ILLEGAL = 3'd2;
   localparam logic [2:0] ST_LOAD    = 3'd3;
   localparam logic [2:0] ST_SEQ     = 3'd4;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [31:0] INSTR_ECALL  = 32'h0000_0073;
   localparam logic [31:0] INSTR_EBREAK = 32'h0010_0073;
   localparam logic [31:0] INSTR_MRET   = 32'h3020_0073;

   localparam logic [11:0] CSR_MSTATUS = 12'h300;
   localparam logic [11:0] CSR_MTVEC   = 12'h305;
   localparam logic [11:0] CSR_MEPC    = 12'h341;
   localparam logic [11:0] CSR_MCAUSE  = 12'h342;

   localparam logic [4:0] REG_A0 = 5'd10;
   localparam logic [4:0] REG_A7 = 5'd17;

   typedef enum logic [1:0] {
      MD_DIV, MD_DIVU, MD_REM, MD_REMU
   } div_op_type;

endpackage

// ===== design/rv32_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, with RISC-V edge cases.
module rv32_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rv32_pkg::div_op_type op,
   input  logic [31:0]         dividend,
   input  logic [31:0]         divisor,
   output logic                done,
   output logic [31:0]         result
);
   import rv32_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, want_rem_ff, want_rem_in;
   logic        special_ff, special_in;
   logic [31:0] special_val_ff, special_val_in;
   logic        done_ff, done_in;
   logic [31:0] result_ff, result_in;

   logic        is_signed, na, nb;
   logic [31:0] ua, ub;
   logic [33:0] trial;
   logic [32:0] shifted_rem;

   always_comb begin
      is_signed = (op == MD_DIV) || (op == MD_REM);
      na = is_signed & dividend[31];
      nb = is_signed & divisor[31];
      ua = na ? (32'd0 - dividend) : dividend;
      ub = nb ? (32'd0 - divisor) : divisor;
      // partial remainder needs 33 bits when the divisor has its top bit set
      shifted_rem = {rem_ff, quot_ff[31]};
      trial = {1'b0, shifted_rem} - {2'b00, dsr_ff};
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      want_rem_in = want_rem_ff;
      special_in = special_ff;
      special_val_in = special_val_ff;
      done_in = 1'b0;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = 6'd32;
         quot_in = ua;
         rem_in = '0;
         dsr_in = ub;
         neg_q_in = na ^ nb;
         neg_r_in = na;
         want_rem_in = (op == MD_REM) || (op == MD_REMU);
         special_in = (divisor == 32'd0);
         special_val_in = ((op == MD_REM) || (op == MD_REMU)) ? dividend : 32'hffff_ffff;
      end else if (busy_ff) begin
         if (count_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (special_ff) begin
               result_in = special_val_ff;
            end else if (want_rem_ff) begin
               result_in = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
            end else begin
               result_in = neg_q_ff ? (32'd0 - quot_ff) : quot_ff;
            end
         end else begin
            count_in = count_ff - 6'd1;
            if (!trial[33]) begin
               rem_in = trial[31:0];
               quot_in = {quot_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted_rem[31:0];
               quot_in = {quot_ff[30:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      want_rem_ff <= want_rem_in;
      special_ff <= special_in;
      special_val_ff <= special_val_in;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

// ===== design/rv32_regfile.sv =====
// 32x32 register memory, one synchronous read port per operand, one write port.
// Entries carry valid bits so that reset reads as zero without a sweep.
module rv32_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] mem_a [32];
   logic [31:0] mem_b [32];
   logic [31:0] valid_ff;
   logic [31:0] data_a_ff, data_b_ff;
   logic        ok_a_ff, ok_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_data;
         mem_b[wr_addr] <= wr_data;
      end
      data_a_ff <= mem_a[rd_addr_a];
      data_b_ff <= mem_b[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_a_ff <= 1'b0;
         ok_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         ok_a_ff <= valid_ff[rd_addr_a] && (rd_addr_a != 5'd0);
         ok_b_ff <= valid_ff[rd_addr_b] && (rd_addr_b != 5'd0);
      end
   end

   assign rd_data_a = ok_a_ff ? data_a_ff : 32'd0;
   assign rd_data_b = ok_b_ff ? data_b_ff : 32'd0;

endmodule

// ===== design/rv32im_instruction_execute.sv =====
// RV32IM execute unit. One instruction or load-data transfer is taken at a time;
// the result goes out through a registered rsp port. Register operands come from a
// 32-entry synchronous memory, so a plain instruction passes through read, execute,
// output staging and the rsp register before rsp_valid rises. ecall and ebreak
// read x17/x10 through the same ports. Multiplies add an S_MUL state: a 33x33
// signed product is registered, then the high or low word is selected. Divides
// and remainders iterate one bit per cycle. Loads issue a read request (status 3);
// the next transfer must be the load data. A new req is accepted while the previous
// rsp still waits: the rsp register frees the execute path, and the req is held in
// the input register until work can begin.
module rv32im_instruction_execute (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rv32_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rv32_pkg::rsp_type rsp_data
);
   import rv32_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     res_ff, res_in;

   logic [31:0] mstatus_ff, mstatus_in, mtvec_ff, mtvec_in;
   logic [31:0] mepc_ff, mepc_in, mcause_ff, mcause_in;
   logic        ld_pend_ff, ld_pend_in;
   logic [4:0]  ld_dest_ff, ld_dest_in;
   logic [2:0]  ld_kind_ff, ld_kind_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0]  mul_sel_ff, mul_sel_in;

   // register memory
   logic [4:0]  ra, rb;
   logic [31:0] a, b;
   logic        wr_en;
   logic [4:0]  wr_addr;
   logic [31:0] wr_data;

   // divider
   logic        div_start, div_done;
   div_op_type  div_op;
   logic [31:0] div_result;

   // decode
   logic [31:0] ins, pc;
   logic [6:0]  opc;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] immi, imms, immb, immj;
   logic [31:0] alu, csr_old, ld_val;
   logic        taken, csr_hit;
   logic [32:0] ma, mb;
   logic [65:0] mprod;

   rv32_regfile u_regs (
      .clock(clock), .reset(reset),
      .rd_addr_a(ra), .rd_addr_b(rb),
      .rd_data_a(a), .rd_data_b(b),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   rv32_divider u_div (
      .clock(clock), .reset(reset),
      .start(div_start), .op(div_op),
      .dividend(a), .divisor(b),
      .done(div_done), .result(div_result)
   );

   assign ins = req_ff.instr;
   assign pc  = req_ff.pc;
   assign opc = ins[6:0];
   assign rd  = ins[11:7];
   assign f3  = ins[14:12];
   assign rs1 = ins[19:15];
   assign rs2 = ins[24:20];
   assign f7  = ins[31:25];
   assign immi = {{20{ins[31]}}, ins[31:20]};
   assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

   // ecall reads x17, ebreak x10 through port a
   always_comb begin
      ra = req_ff.instr[19:15];
      if (req_ff.instr == INSTR_ECALL) begin
         ra = REG_A7;
      end else if (req_ff.instr == INSTR_EBREAK) begin
         ra = REG_A0;
      end
      rb = req_ff.instr[24:20];
   end

   assign div_op = div_op_type'({f3[1], f3[0]});
   assign ma = {(f3 != 3'd3) & a[31], a};
   assign mb = {(f3 != 3'd3) & b[31], b};
   assign mprod = $signed(ma) * $signed(mb);

   always_comb begin
      unique case (ins[31:20])
         CSR_MSTATUS: begin csr_old = mstatus_ff; csr_hit = 1'b1; end
         CSR_MTVEC:   begin csr_old = mtvec_ff;   csr_hit = 1'b1; end
         CSR_MEPC:    begin csr_old = mepc_ff;    csr_hit = 1'b1; end
         CSR_MCAUSE:  begin csr_old = mcause_ff;  csr_hit = 1'b1; end
         default:     begin csr_old = 32'd0;      csr_hit = 1'b0; end
      endcase
   end

   always_comb begin
      unique case (ld_kind_ff)
         3'd0:    ld_val = {{24{req_ff.load_data[7]}}, req_ff.load_data[7:0]};
         3'd1:    ld_val = {{16{req_ff.load_data[15]}}, req_ff.load_data[15:0]};
         3'd4:    ld_val = {24'd0, req_ff.load_data[7:0]};
         3'd5:    ld_val = {16'd0, req_ff.load_data[15:0]};
         default: ld_val = req_ff.load_data;
      endcase
   end

   // execute: compute the ALU result and the branch decision for an instruction
   always_comb begin
      logic [31:0] op2;
      op2 = (opc == OP_REG) ? b : immi;
      alu = 32'd0;
      taken = 1'b0;
      unique case (f3)
         3'd0: alu = (opc == OP_REG && f7 == 7'h20) ? (a - op2) : (a + op2);
         3'd1: alu = a << op2[4:0];
         3'd2: alu = {31'd0, $signed(a) < $signed(op2)};
         3'd3: alu = {31'd0, a < op2};
         3'd4: alu = a ^ op2;
         3'd5: alu = (f7 == 7'h20) ? 32'($signed(a) >>> op2[4:0]) : (a >> op2[4:0]);
         3'd6: alu = a | op2;
         default: alu = a & op2;
      endcase
      unique case (f3)
         3'd0: taken = (a == b);
         3'd1: taken = (a != b);
         3'd4: taken = $signed(a) < $signed(b);
         3'd5: taken = !($signed(a) < $signed(b));
         3'd6: taken = a < b;
         3'd7: taken = a >= b;
         default: taken = 1'b0;
      endcase
   end

   always_comb begin
      rsp_type r;
      logic    illegal, wb;
      logic [31:0] wv;
      state_in = state_ff;
      req_in = req_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      res_in = res_ff;
      mstatus_in = mstatus_ff;
      mtvec_in = mtvec_ff;
      mepc_in = mepc_ff;
      mcause_in = mcause_ff;
      ld_pend_in = ld_pend_ff;
      ld_dest_in = ld_dest_ff;
      ld_kind_in = ld_kind_ff;
      prod_in = prod_ff;
      mul_sel_in = mul_sel_ff;
      div_start = 1'b0;
      wr_en = 1'b0;
      wr_addr = rd;
      wr_data = 32'd0;
      r = '0;
      illegal = 1'b0;
      wb = 1'b0;
      wv = 32'd0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (req_ff.mode) begin
               if (!ld_pend_ff) begin
                  r.status = ST_SEQ;
               end else begin
                  ld_pend_in = 1'b0;
                  if (ld_dest_ff != 5'd0) begin
                     wb = 1'b1;
                     wv = ld_val;
                     wr_addr = ld_dest_ff;
                     r.wb_enable = 1'b1;
                     r.wb_reg = ld_dest_ff;
                     r.wb_value = ld_val;
                  end
               end
               wr_en = wb;
               wr_data = wv;
               res_in = r;
               state_in = S_OUT;
            end else if (ld_pend_ff) begin
               r.next_pc = pc;
               r.status = ST_SEQ;
               res_in = r;
               state_in = S_OUT;
            end else begin
               r.next_pc = pc + 32'd4;
               state_in = S_OUT;
               unique case (opc)
                  OP_LUI:   begin wb = 1'b1; wv = {ins[31:12], 12'd0}; end
                  OP_AUIPC: begin wb = 1'b1; wv = pc + {ins[31:12], 12'd0}; end
                  OP_JAL: begin
                     r.next_pc = pc + immj;
                     wb = 1'b1;
                     wv = pc + 32'd4;
                  end
                  OP_JALR: begin
                     if (f3 != 3'd0) begin
                        illegal = 1'b1;
                     end else begin
                        r.next_pc = (a + immi) & ~32'd1;
                        wb = 1'b1;
                        wv = pc + 32'd4;
                     end
                  end
                  OP_BRANCH: begin
                     if (f3 == 3'd2 || f3 == 3'd3) begin
                        illegal = 1'b1;
                     end else if (taken) begin
                        r.next_pc = pc + immb;
                     end
                  end
                  OP_LOAD: begin
                     if (f3 == 3'd3 || f3 > 3'd5) begin
                        illegal = 1'b1;
                     end else begin
                        r.mem_op = MEM_READ;
                        r.mem_addr = a + immi;
                        r.mem_size = f3[1:0];
                        r.status = ST_LOAD;
                        ld_pend_in = 1'b1;
                        ld_dest_in = rd;
                        ld_kind_in = f3;
                     end
                  end
                  OP_STORE: begin
                     if (f3 > 3'd2) begin
                        illegal = 1'b1;
                     end else begin
                        r.mem_op = MEM_WRITE;
                        r.mem_addr = a + imms;
                        r.mem_size = f3[1:0];
                        r.mem_wdata = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                                      (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                     end
                  end
                  OP_IMM: begin
                     if (f3 == 3'd1 && f7 != 7'h00) begin
                        illegal = 1'b1;
                     end else if (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20) begin
                        illegal = 1'b1;
                     end else begin
                        wb = 1'b1;
                        wv = alu;
                     end
                  end
                  OP_REG: begin
                     if (f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
                        wb = 1'b1;
                        wv = alu;
                     end else if (f7 == 7'h01 && f3 != 3'd2) begin
                        if (f3[2]) begin
                           div_start = 1'b1;
                           state_in = S_DIV;
                        end else begin
                           prod_in = mprod[63:0];
                           mul_sel_in = (f3 == 3'd0) ? 2'd0 : 2'd1;
                           state_in = S_MUL;
                        end
                     end else begin
                        illegal = 1'b1;
                     end
                  end
                  OP_SYSTEM: begin
                     if (f3 == 3'd0) begin
                        if (ins == INSTR_ECALL) begin
                           mcause_in = a;
                           mepc_in = pc;
                           r.next_pc = mtvec_ff;
                        end else if (ins == INSTR_EBREAK) begin
                           r.next_pc = pc;
                           r.status = ST_HALT;
                           r.halt_code = a;
                        end else if (ins == INSTR_MRET) begin
                           r.next_pc = mepc_ff + 32'd4;
                           mstatus_in = {mstatus_ff[31:8], 1'b1, mstatus_ff[6:4],
                                         mstatus_ff[7], mstatus_ff[2:0]};
                        end else begin
                           illegal = 1'b1;
                        end
                     end else if (f3 == 3'd1 || f3 == 3'd2) begin
                        wb = 1'b1;
                        wv = csr_old;
                        if (csr_hit) begin
                           unique case (ins[31:20])
                              CSR_MSTATUS: mstatus_in = (f3 == 3'd1) ? a : (csr_old | a);
                              CSR_MTVEC:   mtvec_in   = (f3 == 3'd1) ? a : (csr_old | a);
                              CSR_MEPC:    mepc_in    = (f3 == 3'd1) ? a : (csr_old | a);
                              default:     mcause_in  = (f3 == 3'd1) ? a : (csr_old | a);
                           endcase
                        end
                     end else begin
                        illegal = 1'b1;
                     end
                  end
                  default: illegal = 1'b1;
               endcase
               if (illegal) begin
                  r = '0;
                  r.next_pc = pc;
                  r.status = ST_ILLEGAL;
                  wb = 1'b0;
               end
               if (wb && rd != 5'd0) begin
                  wr_en = 1'b1;
                  wr_data = wv;
                  r.wb_enable = 1'b1;
                  r.wb_reg = rd;
                  r.wb_value = wv;
               end
               res_in = r;
            end
         end
         S_MUL: begin
            r = res_ff;
            r.next_pc = pc + 32'd4;
            wv = (mul_sel_ff == 2'd0) ? prod_ff[XLEN_BITS-1:0]
                                      : prod_ff[2*XLEN_BITS-1:XLEN_BITS];
            if (rd != 5'd0) begin
               wr_en = 1'b1;
               wr_data = wv;
               r.wb_enable = 1'b1;
               r.wb_reg = rd;
               r.wb_value = wv;
            end
            res_in = r;
            state_in = S_OUT;
         end
         S_DIV: begin
            if (div_done) begin
               r = '0;
               r.next_pc = pc + 32'd4;
               if (rd != 5'd0) begin
                  wr_en = 1'b1;
                  wr_data = div_result;
                  r.wb_enable = 1'b1;
                  r.wb_reg = rd;
                  r.wb_value = div_result;
               end
               res_in = r;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // wait for the rsp register to free up
            if (!out_valid_in) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         mstatus_ff <= '0;
         mtvec_ff <= '0;
         mepc_ff <= '0;
         mcause_ff <= '0;
         ld_pend_ff <= 1'b0;
         ld_dest_ff <= '0;
         ld_kind_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         mstatus_ff <= mstatus_in;
         mtvec_ff <= mtvec_in;
         mepc_ff <= mepc_in;
         mcause_ff <= mcause_in;
         ld_pend_ff <= ld_pend_in;
         ld_dest_ff <= ld_dest_in;
         ld_kind_ff <= ld_kind_in;
      end
      req_ff <= req_in;
      out_ff <= out_in;
      res_ff <= res_in;
      prod_ff <= prod_in;
      mul_sel_ff <= mul_sel_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== dv/tb_rv32im_instruction_execute.sv =====
module tb_rv32im_instruction_execute;
   timeunit 1ns;
   timeprecision 1ps;
   import rv32_pkg::*;

   // Funct codes used when building instructions.
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
   localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
   localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
   localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;
   localparam logic [2:0] F3_SB = 3'd0, F3_SH = 3'd1, F3_SW = 3'd2;
   localparam logic [2:0] F3_PRIV = 3'd0, F3_CSRRW = 3'd1, F3_CSRRS = 3'd2;
   localparam logic MODE_EXEC = 1'b0, MODE_LOAD = 1'b1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rv32im_instruction_execute uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: a shadow of the architectural registers and CSRs.
   logic [31:0] gpr [32];
   logic [31:0] mstatus_q, mtvec_q, mepc_q, mcause_q;
   logic        ld_busy;
   logic [4:0]  ld_rd;
   logic [2:0]  ld_f3;

   rsp_type expected_rsp_q [$];
   int      errors = 0;
   int      n_sent = 0, n_recv = 0;
   int      send_idle_pct = 0, recv_stall_pct = 0;

   // Per-category counters for the summary.
   int n_loads = 0, n_stores = 0, n_muldiv = 0, n_branch = 0, n_sys = 0, n_bad = 0;

   function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
      logic [31:0] m;
      m = 32'h1 << (bits - 1);
      v = v & ((m << 1) - 1);
      return (v ^ m) - m;
   endfunction

   function automatic logic [31:0] div_signed(input logic [31:0] a, input logic [31:0] b,
                                              input logic want_rem);
      logic [31:0] ua, ub, q, r;
      if (b == 0) return want_rem ? a : 32'hffff_ffff;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (want_rem) return a[31] ? -r : r;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic void gpr_write(inout rsp_type r, input logic [4:0] rd,
                                     input logic [31:0] v);
      if (rd == 0) return;
      gpr[rd] = v;
      r.wb_enable = 1'b1;
      r.wb_reg = rd;
      r.wb_value = v;
   endfunction

   // Computes the response for one item and advances the shadow state.
   function automatic rsp_type exec_predict(input req_type q);
      rsp_type     r;
      logic [31:0] ins, a, b, immi, imm, res, t;
      logic [6:0]  opc, f7;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic        ok, taken;
      logic signed [63:0] sp;
      logic [63:0] up;
      r = '0;
      ok = 1'b1;
      ins = q.instr;
      opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
      rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
      if (q.mode == MODE_LOAD) begin
         if (!ld_busy) begin
            r.status = ST_SEQ;
            return r;
         end
         case (ld_f3)
            F3_LB:   res = sext(q.load_data, 8);
            F3_LH:   res = sext(q.load_data, 16);
            F3_LBU:  res = {24'h0, q.load_data[7:0]};
            F3_LHU:  res = {16'h0, q.load_data[15:0]};
            default: res = q.load_data;
         endcase
         gpr_write(r, ld_rd, res);
         ld_busy = 1'b0;
         return r;
      end
      if (ld_busy) begin
         r.next_pc = q.pc;
         r.status = ST_SEQ;
         return r;
      end
      a = gpr[rs1];
      b = gpr[rs2];
      immi = sext({20'h0, ins[31:20]}, 12);
      r.next_pc = q.pc + 4;
      case (opc)
         OP_LUI:   gpr_write(r, rd, {ins[31:12], 12'h0});
         OP_AUIPC: gpr_write(r, rd, q.pc + {ins[31:12], 12'h0});
         OP_JAL: begin
            imm = sext({11'h0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
            r.next_pc = q.pc + imm;
            gpr_write(r, rd, q.pc + 4);
         end
         OP_JALR: begin
            if (f3 != 0) ok = 1'b0;
            else begin
               r.next_pc = (a + immi) & ~32'h1;
               gpr_write(r, rd, q.pc + 4);
            end
         end
         OP_BRANCH: begin
            imm = sext({19'h0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
            taken = 1'b0;
            case (f3)
               F3_BEQ:  taken = a == b;
               F3_BNE:  taken = a != b;
               F3_BLT:  taken = $signed(a) < $signed(b);
               F3_BGE:  taken = !($signed(a) < $signed(b));
               F3_BLTU: taken = a < b;
               F3_BGEU: taken = a >= b;
               default: ok = 1'b0;
            endcase
            if (ok && taken) r.next_pc = q.pc + imm;
         end
         OP_LOAD: begin
            if (f3 == 3 || f3 > 5) ok = 1'b0;
            else begin
               r.mem_op = MEM_READ;
               r.mem_addr = a + immi;
               r.mem_size = f3[1:0];
               r.status = ST_LOAD;
               ld_busy = 1'b1;
               ld_rd = rd;
               ld_f3 = f3;
            end
         end
         OP_STORE: begin
            if (f3 > 2) ok = 1'b0;
            else begin
               imm = sext({20'h0, ins[31:25], ins[11:7]}, 12);
               r.mem_op = MEM_WRITE;
               r.mem_addr = a + imm;
               r.mem_size = f3[1:0];
               r.mem_wdata = (f3 == F3_SB) ? (b & 32'hff) :
                             (f3 == F3_SH) ? (b & 32'hffff) : b;
            end
         end
         OP_IMM: begin
            res = '0;
            case (f3)
               F3_ADD:  res = a + immi;
               F3_SLT:  res = ($signed(a) < $signed(immi)) ? 1 : 0;
               F3_SLTU: res = (a < immi) ? 1 : 0;
               F3_XOR:  res = a ^ immi;
               F3_OR:   res = a | immi;
               F3_AND:  res = a & immi;
               F3_SLL: begin
                  if (f7 != F7_BASE) ok = 1'b0;
                  else res = a << rs2;
               end
               default: begin
                  if (f7 == F7_BASE) res = a >> rs2;
                  else if (f7 == F7_ALT) res = $unsigned($signed(a) >>> rs2);
                  else ok = 1'b0;
               end
            endcase
            if (ok) gpr_write(r, rd, res);
         end
         OP_REG: begin
            res = '0;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  res = a + b;
                  F3_SLL:  res = a << b[4:0];
                  F3_SLT:  res = ($signed(a) < $signed(b)) ? 1 : 0;
                  F3_SLTU: res = (a < b) ? 1 : 0;
                  F3_XOR:  res = a ^ b;
                  F3_SR:   res = a >> b[4:0];
                  F3_OR:   res = a | b;
                  default: res = a & b;
               endcase
            end else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD) res = a - b;
               else if (f3 == F3_SR) res = $unsigned($signed(a) >>> b[4:0]);
               else ok = 1'b0;
            end else if (f7 == F7_MULDIV) begin
               sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               up = {32'h0, a} * {32'h0, b};
               case (f3)
                  F3_MUL:   res = up[31:0];
                  F3_MULH:  res = sp[63:32];
                  F3_MULHU: res = up[63:32];
                  F3_DIV:   res = div_signed(a, b, 1'b0);
                  F3_DIVU:  res = (b == 0) ? 32'hffff_ffff : a / b;
                  F3_REM:   res = div_signed(a, b, 1'b1);
                  F3_REMU:  res = (b == 0) ? a : a % b;
                  default:  ok = 1'b0;
               endcase
            end else ok = 1'b0;
            if (ok) gpr_write(r, rd, res);
         end
         OP_SYSTEM: begin
            if (f3 == F3_PRIV) begin
               if (ins == INSTR_ECALL) begin
                  mcause_q = gpr[REG_A7];
                  mepc_q = q.pc;
                  r.next_pc = mtvec_q;
               end else if (ins == INSTR_EBREAK) begin
                  r.next_pc = q.pc;
                  r.status = ST_HALT;
                  r.halt_code = gpr[REG_A0];
               end else if (ins == INSTR_MRET) begin
                  r.next_pc = mepc_q + 4;
                  t = mstatus_q;
                  t[3] = t[7];
                  mstatus_q = t | 32'h80;
               end else ok = 1'b0;
            end else if (f3 == F3_CSRRW || f3 == F3_CSRRS) begin
               case (ins[31:20])
                  CSR_MSTATUS: begin
                     t = mstatus_q; mstatus_q = (f3 == F3_CSRRW) ? a : (t | a);
                  end
                  CSR_MTVEC: begin
                     t = mtvec_q; mtvec_q = (f3 == F3_CSRRW) ? a : (t | a);
                  end
                  CSR_MEPC: begin
                     t = mepc_q; mepc_q = (f3 == F3_CSRRW) ? a : (t | a);
                  end
                  CSR_MCAUSE: begin
                     t = mcause_q; mcause_q = (f3 == F3_CSRRW) ? a : (t | a);
                  end
                  default: t = '0;
               endcase
               gpr_write(r, rd, t);
            end else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         r = '0;
         r.next_pc = q.pc;
         r.status = ST_ILLEGAL;
      end
      return r;
   endfunction

   // Drives one transfer and waits until it is accepted; the prediction is
   // queued at acceptance so it stays in order with the response stream.
   // Valid drops only when the sender idles, so back-to-back items keep it high.
   task automatic send_item(input req_type q);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp_q.push_back(exec_predict(q));
      n_sent++;
   endtask

   // Response checker with random backpressure.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_recv++;
            if (expected_rsp_q.size() == 0) begin
               $error("response with nothing expected: %p", rsp_data);
               errors++;
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_data.next_pc !== e.next_pc) begin
                  $error("next_pc exp %h got %h", e.next_pc, rsp_data.next_pc); errors++;
               end
               if (rsp_data.mem_op !== e.mem_op) begin
                  $error("mem_op exp %h got %h", e.mem_op, rsp_data.mem_op); errors++;
               end
               if (rsp_data.mem_addr !== e.mem_addr) begin
                  $error("mem_addr exp %h got %h", e.mem_addr, rsp_data.mem_addr); errors++;
               end
               if (rsp_data.mem_size !== e.mem_size) begin
                  $error("mem_size exp %h got %h", e.mem_size, rsp_data.mem_size); errors++;
               end
               if (rsp_data.mem_wdata !== e.mem_wdata) begin
                  $error("mem_wdata exp %h got %h", e.mem_wdata, rsp_data.mem_wdata);
                  errors++;
               end
               if (rsp_data.wb_enable !== e.wb_enable) begin
                  $error("wb_enable exp %h got %h", e.wb_enable, rsp_data.wb_enable);
                  errors++;
               end
               if (rsp_data.wb_reg !== e.wb_reg) begin
                  $error("wb_reg exp %h got %h", e.wb_reg, rsp_data.wb_reg); errors++;
               end
               if (rsp_data.wb_value !== e.wb_value) begin
                  $error("wb_value exp %h got %h", e.wb_value, rsp_data.wb_value); errors++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status exp %h got %h", e.status, rsp_data.status); errors++;
               end
               if (rsp_data.halt_code !== e.halt_code) begin
                  $error("halt_code exp %h got %h", e.halt_code, rsp_data.halt_code);
                  errors++;
               end
            end
         end
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // ---- instruction builders ----
   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] rand_pc();
      case ($urandom_range(3, 0))
         0: return 32'h0;
         1: return 32'hffff_fffc;
         default: return $urandom;
      endcase
   endfunction

   // Operands biased toward corner values for the datapath.
   function automatic logic [31:0] rand_value();
      case ($urandom_range(7, 0))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return 32'h1;
         default: return $urandom;
      endcase
   endfunction

   task automatic exec_instr(input logic [31:0] ins);
      req_type q;
      q.mode = MODE_EXEC;
      q.instr = ins;
      q.pc = rand_pc();
      q.load_data = $urandom;
      send_item(q);
   endtask

   task automatic load_return(input logic [31:0] data);
      req_type q;
      q.mode = MODE_LOAD;
      q.instr = $urandom;
      q.pc = $urandom;
      q.load_data = data;
      send_item(q);
   endtask

   // Puts a full 32-bit value into a register with lui + addi.
   task automatic set_reg(input logic [4:0] rd, input logic [31:0] v);
      logic [31:0] hi;
      hi = v + 32'h800;
      exec_instr({hi[31:12], rd, OP_LUI});
      exec_instr(enc_i(v[11:0], rd, F3_ADD, rd, OP_IMM));
   endtask

   // A random instruction of any legal or illegal shape, weighted to legal.
   task automatic random_instr();
      logic [4:0] rd, r1, r2;
      logic [2:0] f3;
      logic [11:0] csr;
      rd = 5'($urandom); r1 = 5'($urandom); r2 = 5'($urandom); f3 = 3'($urandom);
      case ($urandom_range(19, 0))
         0, 1: set_reg(r1, rand_value());
         2: exec_instr({$urandom_range(1, 0) ? 20'hfffff : 20'($urandom), rd,
                        $urandom_range(1, 0) ? OP_LUI : OP_AUIPC});
         3, 4: exec_instr(enc_r(F7_BASE, r2, r1, f3, rd, OP_REG));
         5: exec_instr(enc_r(F7_ALT, r2, r1, $urandom_range(1, 0) ? F3_ADD : F3_SR,
                             rd, OP_REG));
         6, 7: begin
            exec_instr(enc_r(F7_MULDIV, r2, r1, f3, rd, OP_REG));
            n_muldiv++;
         end
         8, 9: exec_instr(enc_i(12'($urandom), r1, f3, rd, OP_IMM));
         10: exec_instr(enc_i({$urandom_range(1, 0) ? F7_ALT : F7_BASE, 5'($urandom)},
                              r1, $urandom_range(1, 0) ? F3_SLL : F3_SR, rd, OP_IMM));
         11: begin
            exec_instr(enc_b(13'($urandom), r2, r1, f3));
            n_branch++;
         end
         12: exec_instr($urandom_range(1, 0) ? {20'($urandom), 5'($urandom), OP_JAL}
                        : enc_i(12'($urandom), r1, $urandom_range(3, 0) == 0 ? f3 : F3_ADD,
                                rd, OP_JALR));
         13, 14: begin
            f3 = 3'($urandom_range(5, 0));
            exec_instr(enc_i(12'($urandom), r1, f3, rd, OP_LOAD));
            // Mostly complete the load; sometimes poke it with an instruction first.
            if ($urandom_range(4, 0) == 0) exec_instr($urandom);
            if ($urandom_range(9, 0) != 0) load_return($urandom);
            n_loads++;
         end
         15: begin
            exec_instr(enc_s(12'($urandom), r2, r1, 3'($urandom_range(3, 0))));
            n_stores++;
         end
         16: begin
            case ($urandom_range(4, 0))
               0: csr = CSR_MSTATUS;
               1: csr = CSR_MTVEC;
               2: csr = CSR_MEPC;
               3: csr = CSR_MCAUSE;
               default: csr = 12'($urandom);
            endcase
            exec_instr(enc_i(csr, r1, 3'($urandom_range(3, 0)), rd, OP_SYSTEM));
            n_sys++;
         end
         17: begin
            case ($urandom_range(3, 0))
               0: exec_instr(INSTR_ECALL);
               1: exec_instr(INSTR_EBREAK);
               2: exec_instr(INSTR_MRET);
               default: exec_instr(enc_i(12'($urandom), r1, F3_PRIV, rd, OP_SYSTEM));
            endcase
            n_sys++;
         end
         18: load_return($urandom);
         default: begin
            exec_instr($urandom);
            n_bad++;
         end
      endcase
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // ---- tests ----
   task automatic test_alu_directed();
      set_reg(5'd1, 32'h8000_0000);
      set_reg(5'd2, 32'hffff_ffff);
      exec_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OP_REG));   // overflow
      exec_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd3, OP_REG));
      exec_instr(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd3, OP_REG));   // divide by 0
      exec_instr(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_REMU, 5'd3, OP_REG));
      exec_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd4, OP_REG));
      exec_instr(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MULHSU, 5'd4, OP_REG)); // illegal
      exec_instr(enc_r(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd5, OP_REG));        // sra by 31
      exec_instr(enc_i({F7_ALT | 7'h1, 5'd3}, 5'd1, F3_SR, 5'd5, OP_IMM)); // bit 25 set
      exec_instr(enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd0, OP_REG));      // write x0
   endtask

   task automatic test_memory_directed();
      exec_instr(enc_i(12'h7ff, 5'd2, F3_LH, 5'd6, OP_LOAD));
      exec_instr(32'h0000_0013);                                         // while pending
      load_return(32'h0000_8001);
      load_return(32'h1234_5678);                                        // none pending
      exec_instr(enc_i(12'h800, 5'd1, F3_LB, 5'd0, OP_LOAD));            // into x0
      load_return(32'hffff_ffff);
      exec_instr(enc_i(12'h004, 5'd1, F3_LW, 5'd7, OP_LOAD));
      load_return(32'h89ab_cdef);
      exec_instr(enc_s(12'hfff, 5'd2, 5'd1, F3_SB));
      exec_instr(enc_s(12'h008, 5'd7, 5'd1, F3_SW));
      exec_instr(enc_b(13'h1ffe, 5'd2, 5'd2, F3_BEQ));
   endtask

   task automatic test_system_directed();
      set_reg(REG_A7, 32'hdead_beef);
      exec_instr(enc_i(CSR_MTVEC, 5'd1, F3_CSRRW, 5'd7, OP_SYSTEM));
      exec_instr(INSTR_ECALL);
      exec_instr(enc_i(CSR_MSTATUS, 5'd2, F3_CSRRS, 5'd8, OP_SYSTEM));
      exec_instr(INSTR_MRET);
      exec_instr(enc_i(12'h123, 5'd2, F3_CSRRW, 5'd9, OP_SYSTEM));       // unknown CSR
      exec_instr(INSTR_EBREAK);
   endtask

   task automatic test_random(input int n_items, input int idle, input int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      while (n_items > 0) begin
         random_instr();
         n_items--;
      end
   endtask

   initial begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      mstatus_q = '0; mtvec_q = '0; mepc_q = '0; mcause_q = '0;
      ld_busy = 1'b0; ld_rd = '0; ld_f3 = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_alu_directed();
      test_memory_directed();
      test_system_directed();
      // Idle phases: none, sender gaps, receiver stalls, then both.
      test_random(250, 0, 0);
      test_random(250, 49, 0);
      test_random(250, 0, 49);
      test_random(250, 19, 19);
      wait_drain();
      recv_stall_pct = 0;
      repeat (50) @(posedge clock);
      $display("%0d items sent, %0d responses checked: %0d loads, %0d stores,",
               n_sent, n_recv, n_loads, n_stores);
      $display("%0d mul/div, %0d branches, %0d system ops, %0d raw words; %0d errors",
               n_muldiv, n_branch, n_sys, n_bad, errors);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Worst case is every item taking a divide plus stall gaps, far below this.
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
